// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/vlfs_pkg.sv =====
// Shared types and status codes of the varint frame splitter.
`default_nettype none

package vlfs_pkg;

    typedef enum logic [2:0] {
        ST_PREFIX   = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_LIMIT    = 3'd3,
        ST_DISCARD  = 3'd4
    } status_t;

    localparam int CFG_W      = 32;
    localparam int FRAME_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int LAST_INDEX = 9;
    localparam int CHUNK_W    = 7;
    localparam int SPAN_W     = 70;

    // Per-byte verdict of the length accumulator.
    typedef struct packed {
        logic overflow;
        logic more;
        logic too_long;
        logic empty;
    } accum_flags_t;

endpackage

`default_nettype wire

// ===== rtl/varint_length_frame_splitter.sv =====
// Top level: varint length-prefixed frame splitter with a registered result stage.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  byte in  | byte_valid / byte_stall   | data_byte
//  result   | result_valid/result_stall | status, payload_byte, frame_last, frame_length
//  config   | cfg_valid / cfg_ready     | cfg_data (max_frame_size)
//
// One byte per cycle while byte_stall is low; each result appears in the cycle
// after its byte is taken. The rate is set by the single result register: it
// refills on the edge it drains. byte_stall rises only while a result is held
// under result_stall. cfg_ready is always high. Reset sets max_frame_size to all
// ones and restarts prefix collection; an error holds until reset.
`default_nettype none

module varint_length_frame_splitter #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       status,
    output logic [7:0]       payload_byte,
    output logic             frame_last,
    output logic [31:0]      frame_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import vlfs_pkg::*;

    localparam int ACC_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    typedef enum logic [1:0] {
        M_PREFIX  = 2'd0,
        M_PAYLOAD = 2'd1,
        M_HALT    = 2'd2
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 wide_reg, wide_next;
    logic [FRAME_W-1:0]   remain_reg, remain_next;
    logic [CFG_W-1:0]     max_size_reg;

    logic                 valid_reg;
    status_t              status_reg, status_next;
    logic [7:0]           pbyte_reg, pbyte_next;
    logic                 last_reg, last_next;
    logic [FRAME_W-1:0]   flen_reg, flen_next;

    logic [ACC_W-1:0]     acc_upd;
    logic                 wide_upd;
    accum_flags_t         flags;
    logic [FRAME_W-1:0]   remain_dec;
    logic                 accept;

    vlfs_accum #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_accum (
        .count          (count_reg),
        .data_byte      (data_byte),
        .max_frame_size (max_size_reg),
        .acc            (acc_reg),
        .wide           (wide_reg),
        .acc_next       (acc_upd),
        .wide_next      (wide_upd),
        .flags          (flags)
    );

    assign byte_stall = valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;
    assign cfg_ready  = 1'b1;

    assign remain_dec = remain_reg - FRAME_W'(remain_reg != '0);

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        wide_next   = wide_reg;
        remain_next = remain_reg;
        status_next = ST_DISCARD;
        pbyte_next  = 8'd0;
        last_next   = 1'b0;
        flen_next   = '0;
        case (mode_reg)
            M_PAYLOAD:
            begin
                remain_next = remain_dec;
                status_next = ST_PAYLOAD;
                pbyte_next  = data_byte;
                last_next   = (remain_dec == '0);
                if (remain_dec == '0)
                begin
                    mode_next = M_PREFIX;
                end
            end
            M_PREFIX:
            begin
                status_next = ST_PREFIX;
                if (flags.overflow)
                begin
                    mode_next   = M_HALT;
                    status_next = ST_OVERFLOW;
                end
                else if (flags.more)
                begin
                    count_next = count_reg + COUNT_W'(1);
                    acc_next   = acc_upd;
                    wide_next  = wide_upd;
                end
                else
                begin
                    // length complete: restart the accumulator either way
                    count_next = '0;
                    acc_next   = '0;
                    wide_next  = 1'b0;
                    if (flags.too_long)
                    begin
                        mode_next   = M_HALT;
                        status_next = ST_LIMIT;
                        flen_next   = acc_upd[FRAME_W-1:0];
                    end
                    else if (flags.empty)
                    begin
                        last_next = 1'b1;
                    end
                    else
                    begin
                        mode_next   = M_PAYLOAD;
                        remain_next = acc_upd[FRAME_W-1:0];
                        flen_next   = acc_upd[FRAME_W-1:0];
                    end
                end
            end
            default:
            begin
                mode_next = M_HALT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_PREFIX;
            count_reg    <= '0;
            acc_reg      <= '0;
            wide_reg     <= 1'b0;
            remain_reg   <= '0;
            max_size_reg <= '1;
            valid_reg    <= 1'b0;
            status_reg   <= ST_PREFIX;
            pbyte_reg    <= 8'd0;
            last_reg     <= 1'b0;
            flen_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_size_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                acc_reg    <= acc_next;
                wide_reg   <= wide_next;
                remain_reg <= remain_next;
                valid_reg  <= 1'b1;
                status_reg <= status_next;
                pbyte_reg  <= pbyte_next;
                last_reg   <= last_next;
                flen_reg   <= flen_next;
            end
            else if (!result_stall)
            begin
                // drain the result word
                valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign payload_byte = pbyte_reg;
    assign frame_last   = last_reg;
    assign frame_length = flen_reg;

endmodule

`default_nettype wire

// ===== rtl/vlfs_accum.sv =====
// Varint length accumulator: places one 7-bit group and checks the finished length.
`default_nettype none

module vlfs_accum #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic [vlfs_pkg::COUNT_W-1:0] count,
    input  wire logic [7:0]                   data_byte,
    input  wire logic [vlfs_pkg::CFG_W-1:0]   max_frame_size,
    input  wire logic [((LENGTH_BITS > 32) ? LENGTH_BITS : 32)-1:0] acc,
    input  wire logic                         wide,
    output logic [((LENGTH_BITS > 32) ? LENGTH_BITS : 32)-1:0] acc_next,
    output logic                              wide_next,
    output vlfs_pkg::accum_flags_t            flags
);
    import vlfs_pkg::*;

    localparam int ACC_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam logic [ACC_W-1:0] LOW_MASK =
        ({{(ACC_W-1){1'b0}}, 1'b1} << LENGTH_BITS) - {{(ACC_W-1){1'b0}}, 1'b1};

    logic [SPAN_W-1:0] contrib;
    logic              at_last;

    assign at_last = (count >= COUNT_W'(LAST_INDEX));

    always_comb
    begin
        contrib = '0;
        for (int k = 0; k <= LAST_INDEX; k++)
        begin
            if (count == COUNT_W'(k))
            begin
                contrib = SPAN_W'(data_byte[CHUNK_W-1:0]) << (CHUNK_W * k);
            end
        end
    end

    assign acc_next  = acc | contrib[ACC_W-1:0];
    assign wide_next = wide | (|contrib[SPAN_W-1:ACC_W]);

    always_comb
    begin
        flags.overflow = at_last && (data_byte[7:1] != 7'd0);
        flags.more     = data_byte[7] && !at_last;
        flags.too_long = wide_next || (|(acc_next & ~LOW_MASK))
                         || (acc_next > ACC_W'(max_frame_size));
        flags.empty    = (acc_next == '0) && !wide_next;
    end

endmodule

`default_nettype wire

// ===== rtl/vlfs_checker.sv =====
// Port-level checks of the varint frame splitter and their bind.
`default_nettype none
`include "assert_macros.svh"

module vlfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       byte_valid,
    input wire logic       byte_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [2:0] status,
    input wire logic [7:0] payload_byte,
    input wire logic       frame_last
);
    import vlfs_pkg::*;

    logic halted_reg;
    logic out_take;
    logic is_error;

    assign out_take = result_valid && !result_stall;
    assign is_error = (status == ST_OVERFLOW) || (status == ST_LIMIT)
                      || (status == ST_DISCARD);

    // remember that an error word has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b0;
        end
        else if (out_take && is_error)
        begin
            halted_reg <= 1'b1;
        end
    end

    `VL_ASSERT_NXT(a_hold_word, result_valid && result_stall,
                   result_valid && $stable(status) && $stable(payload_byte))
    `VL_ASSERT_IMP(a_halt_sticks, out_take && halted_reg, status == ST_DISCARD)
    `VL_ASSERT_IMP(a_stall_cause, byte_stall, result_valid && result_stall)
    `VL_ASSERT_IMP(a_byte_only_payload, result_valid && (status != ST_PAYLOAD),
                   payload_byte == 8'd0)
    `VL_ASSERT_IMP(a_last_kind, result_valid && frame_last && byte_valid,
                   (status == ST_PREFIX) || (status == ST_PAYLOAD))

endmodule

bind varint_length_frame_splitter vlfs_checker u_vlfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .payload_byte (payload_byte),
    .frame_last   (frame_last)
);

`default_nettype wire

// ===== tb/varint_frame_checker.sv =====
// Checker for the varint frame splitter: predicts each result word and compares it on arrival.
`timescale 1ns / 100ps

module varint_frame_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic [2:0]  status,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        frame_last,
    input  wire logic [31:0] frame_length,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    import vlfs_pkg::*;

    typedef enum logic [1:0] {
        SPLIT_PREFIX,
        SPLIT_BODY,
        SPLIT_HALTED
    } split_mode_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload;
        logic        last;
        logic [31:0] length;
    } frame_word_t;

    split_mode_t        split_mode;
    logic [COUNT_W-1:0] prefix_cnt;
    logic [63:0]        length_acc;
    logic [FRAME_W-1:0] body_left;
    logic [CFG_W-1:0]   size_limit;
    frame_word_t        expected_words[$];
    int                 errors = 0;

    function automatic frame_word_t make_word(input status_t s, input logic [7:0] p,
                                              input logic l, input logic [31:0] n);
        frame_word_t w;
        w.status  = s;
        w.payload = p;
        w.last    = l;
        w.length  = n;
        return w;
    endfunction

    // Advance the splitter state by one byte and return the word it produces.
    function automatic frame_word_t split_byte(input logic [7:0] b);
        logic [COUNT_W-1:0] p;
        logic [63:0]        len;
        logic               too_wide;
        if (split_mode == SPLIT_BODY) begin
            if (body_left != 0)
                body_left = body_left - 1;
            if (body_left == 0)
                split_mode = SPLIT_PREFIX;
            return make_word(ST_PAYLOAD, b, body_left == 0, '0);
        end
        if (split_mode != SPLIT_PREFIX) begin
            split_mode = SPLIT_HALTED;
            return make_word(ST_DISCARD, '0, 1'b0, '0);
        end
        p = (prefix_cnt > LAST_INDEX) ? COUNT_W'(LAST_INDEX) : prefix_cnt;
        // tenth byte may only carry bit 0
        if (p == LAST_INDEX && (b & 8'hfe) != 0) begin
            split_mode = SPLIT_HALTED;
            return make_word(ST_OVERFLOW, '0, 1'b0, '0);
        end
        length_acc = length_acc | ({57'd0, b[6:0]} << (CHUNK_W * p));
        if (b[7] && p < LAST_INDEX) begin
            prefix_cnt = p + 1'b1;
            return make_word(ST_PREFIX, '0, 1'b0, '0);
        end
        len        = length_acc;
        prefix_cnt = '0;
        length_acc = '0;
        too_wide   = (LENGTH_BITS < 64) && ((len >> LENGTH_BITS) != 0);
        if (len > {32'd0, size_limit} || too_wide) begin
            split_mode = SPLIT_HALTED;
            return make_word(ST_LIMIT, '0, 1'b0, len[31:0]);
        end
        if (len == 0)
            return make_word(ST_PREFIX, '0, 1'b1, '0);
        body_left  = len[31:0];
        split_mode = SPLIT_BODY;
        return make_word(ST_PREFIX, '0, 1'b0, len[31:0]);
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        frame_word_t want;
        frame_word_t got;
        if (!rst_n)
        begin
            split_mode = SPLIT_PREFIX;
            prefix_cnt = '0;
            length_acc = '0;
            body_left  = '0;
            size_limit = '1;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_limit = cfg_data;
            if (byte_valid && !byte_stall)
                expected_words.insert(expected_words.size(), split_byte(data_byte));
            if (result_valid && !result_stall)
            begin
                got = make_word(status_t'(status), payload_byte, frame_last, frame_length);
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual status %0d byte %0d",
                             $time, status, payload_byte);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("payload_byte", 32'(want.payload), 32'(payload_byte));
                    check_field("frame_last", 32'(want.last), 32'(frame_last));
                    check_field("frame_length", want.length, frame_length);
                end
            end
            pending <= expected_words.size();
        end
        fail_count <= errors;
    end

endmodule

// ===== tb/tb_varint_length_frame_splitter.sv =====
// Testbench top for the varint frame splitter: drives bytes and config, gives the verdict.
`timescale 1ns / 100ps

module tb_varint_length_frame_splitter;

    localparam int LENGTH_BITS = 32;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        END_OVERFLOW,
        END_OVER_LIMIT,
        END_TOO_WIDE,
        END_TENTH_ONE
    } halt_cause_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte    = 8'd0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [31:0] frame_length;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data     = 32'd0;

    int   fail_count;
    int   pending;
    int   sent        = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req    = 1'b0;
    bit   hold_used   = 1'b0;
    int   hold_left   = 0;
    int   stuck       = 0;

    varint_length_frame_splitter #(
        .LENGTH_BITS (LENGTH_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    varint_frame_checker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off to back up the input.
    always @(posedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    initial
    begin : watchdog
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_prefix(input logic [63:0] len, input int total);
        logic [63:0] shifted;
        for (int i = 0; i < total; i++)
        begin
            shifted = len >> (7 * i);
            send_byte({i < total - 1, shifted[6:0]});
        end
    endtask

    function automatic int varint_span(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    // Optionally pad the prefix with zero chunks up to the ten-byte maximum.
    function automatic int prefix_bytes(input logic [63:0] v);
        int n;
        n = varint_span(v);
        if ($urandom_range(0, 99) < 25)
            n = n + $urandom_range(0, 10 - n);
        return n;
    endfunction

    function automatic logic [31:0] pick_length(input logic [31:0] limit);
        int          r;
        logic [31:0] n;
        r = $urandom_range(0, 99);
        if (r < 15)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 16);
        else
            n = $urandom_range(17, 200);
        if (n > limit)
            n = limit;
        return n;
    endfunction

    task automatic send_frame(input logic [31:0] len);
        send_prefix({32'd0, len}, prefix_bytes({32'd0, len}));
        repeat (len)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic drain;
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] limit;
        logic [63:0] big;
        int          target;
        halt_cause_t cause;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 24;
        rx_idle_pct <= 79;
        send_byte(8'h00);
        send_prefix(64'd0, 10);
        send_byte(8'h01);
        send_byte(8'hff);
        send_prefix(64'd1, 2);
        send_byte(8'h80);
        send_byte(8'h03);
        send_byte(8'h7f);
        send_byte(8'h55);
        send_byte(8'haa);
        drain();
        write_limit(32'd0);
        send_byte(8'h00);
        send_prefix(64'd0, 3);
        drain();
        write_limit(32'd3);
        send_frame(32'd3);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0: begin tx_idle_pct = 24; rx_idle_pct <= 79; limit = $urandom_range(8, 64); end
                1: begin tx_idle_pct = 79; rx_idle_pct <= 24; limit = $urandom_range(130, 400); end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    limit = 32'hffff_ffff;
                end
            endcase
            write_limit(limit);
            if (phase == 2)
                hold_req <= 1'b1;
            target = sent + 490;
            while (sent < target)
                send_frame(pick_length(limit));
        end

        // Finish on one error; the block stays halted until reset.
        drain();
        cause = halt_cause_t'($urandom_range(0, 3));
        case (cause)
            END_OVERFLOW:
            begin
                repeat (9) send_byte(8'h80 | 8'($urandom_range(0, 127)));
                send_byte(8'($urandom_range(2, 255)));
            end
            END_OVER_LIMIT:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    limit = 32'hffff_fffe;
                    big   = 64'hffff_ffff;
                end
                else
                begin
                    limit = $urandom_range(0, 1000);
                    big   = {32'd0, limit} + 64'd1 + 64'($urandom_range(0, 5000));
                end
                write_limit(limit);
                send_prefix(big, prefix_bytes(big));
            end
            END_TOO_WIDE:
            begin
                big = {1'b0, 31'($urandom_range(1, 32'h7fff_ffff)), 32'($urandom)};
                send_prefix(big, prefix_bytes(big));
            end
            default:
            begin
                repeat (9) send_byte(8'h80 | 8'($urandom_range(0, 127)));
                send_byte(8'h01);
            end
        endcase
        repeat (12) send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
